/* rtl/frp_pkg.sv */
// Package: shared types, constants and the residue lookup for the FASTA residue parser.
package frp_pkg;

    // Field and counter widths
    localparam int unsigned POS_W        = 20;
    localparam int unsigned LENGTH_BITS  = 20;
    localparam int unsigned HPOS_W       = 6;
    localparam int unsigned HEADER_LIMIT = 48;
    localparam int unsigned QDEPTH       = 4;
    localparam int unsigned QIDX_W       = 2;
    localparam int unsigned QCNT_W       = 3;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [HPOS_W-1:0] HPOS_LIMIT = HPOS_W'(HEADER_LIMIT);

    // Character codes
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_B = 8'h62;
    localparam logic [7:0] CH_LOW_C = 8'h63;
    localparam logic [7:0] CH_LOW_D = 8'h64;
    localparam logic [7:0] CH_LOW_E = 8'h65;
    localparam logic [7:0] CH_LOW_G = 8'h67;
    localparam logic [7:0] CH_LOW_J = 8'h6A;
    localparam logic [7:0] CH_LOW_N = 8'h6E;
    localparam logic [7:0] CH_LOW_O = 8'h6F;
    localparam logic [7:0] CH_LOW_T = 8'h74;
    localparam logic [7:0] CH_LOW_U = 8'h75;
    localparam logic [7:0] CH_LOW_V = 8'h76;
    localparam logic [7:0] CH_LOW_W = 8'h77;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_LOW_Y = 8'h79;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Parser phase
    typedef enum logic [1:0] {
        PH_SEEK   = 2'd0,
        PH_HEADER = 2'd1,
        PH_SEQ    = 2'd2
    } t_phase;

    // Result kind codes
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_RESIDUE = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        value;
        logic [POS_W-1:0]  position;
        logic              invalid;
        logic              done;
        logic              last;
    } t_result;

    // Results of one byte: up to two
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_dec_out;

    typedef struct packed {
        logic [4:0] code;
        logic       bad;
    } t_residue;

    // Fold case, remap by alphabet, range check
    function automatic t_residue residue_map(input logic [7:0] b, input logic dna);
        logic [7:0] c;
        logic       warn;
        t_residue   r;
        c    = (b < CH_LOW_A) ? (b + CASE_OFS) : b;
        warn = 1'b0;
        if (dna) begin
            case (c)
                CH_LOW_A, CH_LOW_C: c = c;
                CH_LOW_N, CH_LOW_X: c = CH_LOW_E;
                CH_LOW_T:           c = CH_LOW_B;
                CH_LOW_G:           c = CH_LOW_D;
                default:            warn = 1'b1;
            endcase
        end else begin
            case (c)
                CH_LOW_V: c = CH_LOW_B;
                CH_LOW_W: c = CH_LOW_J;
                CH_LOW_Y: c = CH_LOW_O;
                CH_LOW_X: c = CH_LOW_U;
                default:  c = c;
            endcase
        end
        if (c < CH_LOW_A || c > CH_LOW_U) begin
            c    = CH_LOW_X;
            warn = 1'b1;
        end
        c      = c - CH_LOW_A;
        r.code = c[4:0];
        r.bad  = warn;
        return r;
    endfunction

endpackage

/* rtl/frp_if.sv */
// Interfaces: input byte channel, result channel and configuration write channel.
interface frp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_input;

    modport source (output valid, output text_byte, output end_of_input, input ready);
    modport sink   (input valid, input text_byte, input end_of_input, output ready);
endinterface

interface frp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  value;
    logic [19:0] position;
    logic        invalid_residue;
    logic        stream_done;
    logic        last_of_run;

    modport source (output valid, output result_kind, output value, output position,
                    output invalid_residue, output stream_done, output last_of_run,
                    input ready);
    modport sink   (input valid, input result_kind, input value, input position,
                    input invalid_residue, input stream_done, input last_of_run,
                    output ready);
endinterface

interface frp_cfg_if;
    logic valid;
    logic ready;
    logic alphabet_is_dna;

    modport source (output valid, output alphabet_is_dna, input ready);
    modport sink   (input valid, input alphabet_is_dna, output ready);
endinterface

/* rtl/frp_decode.sv */
// Decoder: parser phase, header and sequence counters, and per-byte result generation.
module frp_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    input  logic              i_eoi,
    input  logic              i_dna,
    output frp_pkg::t_dec_out o_dec
);
    import frp_pkg::*;

    t_phase                  r_phase, n_phase;
    logic [HPOS_W-1:0]       r_hpos, n_hpos;
    logic [LENGTH_BITS-1:0]  r_len, n_len;
    t_residue                res;
    logic [31:0]             len_wide;
    logic [POS_W-1:0]        len_pos;

    assign res      = residue_map(i_byte, i_dna);
    // Saturate the reported length at the position field's maximum
    assign len_wide = 32'(r_len);
    assign len_pos  = (len_wide > 32'(POS_MAX)) ? POS_MAX : len_wide[POS_W-1:0];

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_hpos  = r_hpos;
        n_len   = r_len;
        if (i_eoi) begin
            n_phase = PH_SEEK;
            n_hpos  = '0;
            n_len   = '0;
        end else begin
            case (r_phase)
                PH_HEADER: begin
                    if (i_byte == CH_NL) begin
                        n_phase = PH_SEQ;
                        n_len   = '0;
                    end else if (r_hpos < HPOS_LIMIT) begin
                        n_hpos = r_hpos + 1'b1;
                    end
                end
                PH_SEQ: begin
                    if (i_byte == CH_GT) begin
                        n_phase = PH_HEADER;
                        n_hpos  = '0;
                        n_len   = '0;
                    end else if (i_byte != CH_SP && i_byte != CH_NL && i_byte != CH_TAB) begin
                        if (r_len != LEN_MAX) begin
                            n_len = r_len + 1'b1;
                        end
                    end
                end
                default: begin
                    if (i_byte == CH_GT) begin
                        n_phase = PH_HEADER;
                        n_hpos  = '0;
                        n_len   = '0;
                    end
                end
            endcase
        end
    end

    // Results for the byte at hand
    always_comb begin
        o_dec          = '0;
        o_dec.res0.last = 1'b1;
        o_dec.res1.last = 1'b1;
        if (i_eoi) begin
            if (r_phase == PH_HEADER || r_phase == PH_SEQ) begin
                o_dec.count         = 2'd1;
                o_dec.res0.kind     = KIND_END;
                o_dec.res0.position = (r_phase == PH_SEQ) ? len_pos : '0;
                o_dec.res0.done     = 1'b1;
            end
        end else begin
            case (r_phase)
                PH_HEADER: begin
                    if (i_byte != CH_NL && r_hpos < HPOS_LIMIT) begin
                        o_dec.count         = 2'd1;
                        o_dec.res0.kind     = KIND_HEADER;
                        o_dec.res0.value    = i_byte;
                        o_dec.res0.position = POS_W'(r_hpos) + 1'b1;
                    end
                end
                PH_SEQ: begin
                    if (i_byte == CH_GT) begin
                        o_dec.count         = 2'd2;
                        o_dec.res0.kind     = KIND_END;
                        o_dec.res0.position = len_pos;
                        o_dec.res0.last     = 1'b0;
                        o_dec.res1.kind     = KIND_HEADER;
                        o_dec.res1.value    = i_byte;
                    end else if (i_byte != CH_SP && i_byte != CH_NL && i_byte != CH_TAB) begin
                        o_dec.count         = 2'd1;
                        o_dec.res0.kind     = KIND_RESIDUE;
                        o_dec.res0.value    = {3'b000, res.code};
                        o_dec.res0.position = len_pos;
                        o_dec.res0.invalid  = res.bad;
                    end
                end
                default: begin
                    if (i_byte == CH_GT) begin
                        o_dec.count      = 2'd1;
                        o_dec.res0.kind  = KIND_HEADER;
                        o_dec.res0.value = i_byte;
                    end
                end
            endcase
        end
    end

    // Advance state on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_hpos  <= '0;
            r_len   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_hpos  <= n_hpos;
            r_len   <= n_len;
        end
    end

`ifndef SYNTHESIS
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_dec.count == 2'd2) |->
            (o_dec.res0.kind == KIND_END && o_dec.res1.kind == KIND_HEADER
             && o_dec.res1.last && !o_dec.res0.last))
        else $error("two-result byte not record end then header");

    a_eoi_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_eoi) |=> (r_phase == PH_SEEK && r_len == '0 && r_hpos == '0))
        else $error("end of input did not clear parser state");
`endif

endmodule

/* rtl/frp_outq.sv */
// Result queue: four-entry FIFO taking up to two results per cycle, one out per cycle while i_ready is high.
module frp_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  frp_pkg::t_dec_out i_dec,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output frp_pkg::t_result  o_res
);
    import frp_pkg::*;

    t_result             r_mem [QDEPTH];
    logic [QIDX_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_count;
    logic [QCNT_W-1:0]   push_n;
    logic                pop;
    logic [QIDX_W-1:0]   wr_next;

    assign push_n  = i_push ? QCNT_W'(i_dec.count) : '0;
    assign pop     = (r_count != '0) && i_ready;
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd];
    assign o_room  = (r_count <= QCNT_W'(QDEPTH - 2));
    assign wr_next = r_wr + 1'b1;

    // Store incoming results
    always_ff @(posedge i_clk) begin
        if (push_n != '0) begin
            r_mem[r_wr] <= i_dec.res0;
        end
        if (push_n == QCNT_W'(2)) begin
            r_mem[wr_next] <= i_dec.res1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + QIDX_W'(push_n);
            r_rd    <= r_rd + QIDX_W'(pop);
            r_count <= r_count + push_n - QCNT_W'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n != '0) |-> (r_count + push_n <= QCNT_W'(QDEPTH)))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("result queue count out of range");
`endif

endmodule

/* rtl/fasta_residue_parser_unit.sv */
// Top level: FASTA residue parser with input register, decoder and result queue.
//
//  port    | dir | contents
//  --------+-----+----------------------------------------------------------
//  i_in    | in  | text_byte, end_of_input
//  o_out   | out | result_kind, value, position, invalid_residue,
//          |     | stream_done, last_of_run
//  i_cfg   | in  | alphabet_is_dna (always ready)
//
// One byte per cycle while the queue has room: a byte is registered, then decoded, and
// its zero, one or two results land in a four-entry result queue.
// A registered byte is decoded only while the queue has two free slots.
// Reset is synchronous; it clears phase, counters, queue and alphabet select.
module fasta_residue_parser_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    frp_in_if.sink    i_in,
    frp_out_if.source o_out,
    frp_cfg_if.sink   i_cfg
);
    import frp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_eoi;
    logic       r_dna;
    logic       dec_fire;
    logic       room;
    t_dec_out   dec;
    t_result    qres;

    assign dec_fire   = r_in_valid && room;
    assign i_in.ready = !r_in_valid || dec_fire;
    assign i_cfg.ready = 1'b1;

    // Hold the input byte until decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.text_byte;
            r_eoi  <= i_in.end_of_input;
        end
    end

    // Alphabet select register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dna <= 1'b0;
        end else if (i_cfg.valid) begin
            r_dna <= i_cfg.alphabet_is_dna;
        end
    end

    frp_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (dec_fire),
        .i_byte  (r_byte),
        .i_eoi   (r_eoi),
        .i_dna   (r_dna),
        .o_dec   (dec)
    );

    frp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (dec_fire),
        .i_dec   (dec),
        .o_room  (room),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (qres)
    );

    // Drive result payload
    assign o_out.result_kind     = qres.kind;
    assign o_out.value           = qres.value;
    assign o_out.position        = qres.position;
    assign o_out.invalid_residue = qres.invalid;
    assign o_out.stream_done     = qres.done;
    assign o_out.last_of_run     = qres.last;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for the FASTA residue parser: a directed stimulus table, then random records.
module tb_top;
    import frp_pkg::*;

    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CODE_INVALID = 8'd23;

    typedef enum int { ROW_BYTE, ROW_EOI, ROW_CFG } t_row_op;

    typedef struct {
        t_row_op    op;
        logic [7:0] b;
        bit         typed;
        int         n;
        t_result    res;
    } t_stim_row;

    logic clk;
    logic rst_n;

    frp_in_if  in_if();
    frp_out_if out_if();
    frp_cfg_if cfg_if();

    fasta_residue_parser_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Parser state as the testbench sees it
    t_phase      mdl_phase   = PH_SEEK;
    int unsigned mdl_hdr_pos = 0;
    logic [19:0] mdl_seq_len = '0;
    logic        mdl_dna     = 1'b0;

    t_result     pending_results[$];
    t_result     step_results[$];
    t_stim_row   dir_rows[$];
    bit          failed    = 1'b0;
    bit          idle_on   = 1'b1;
    int          hold_req  = 0;

    // Expectation typed into the table for the item on offer
    bit          cur_typed = 1'b0;
    int          cur_n     = 0;
    t_result     cur_res   = '0;

    // Clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic t_result mk_res(input t_kind kind, input logic [7:0] val,
                                       input logic [19:0] pos, input logic bad,
                                       input logic done, input logic last);
        t_result r;
        r.kind     = kind;
        r.value    = val;
        r.position = pos;
        r.invalid  = bad;
        r.done     = done;
        r.last     = last;
        return r;
    endfunction

    // Fold case, remap by alphabet, flag what falls outside a..u
    function automatic void map_residue(input logic [7:0] b, input logic dna,
                                        output logic [7:0] code, output logic bad);
        logic [7:0] c;
        c   = (b < 8'd97) ? b + 8'd32 : b;
        bad = 1'b0;
        if (dna) begin
            if (c == "t") c = "b";
            else if (c == "g") c = "d";
            else if (c == "n" || c == "x") c = "e";
            else if (c != "a" && c != "c") bad = 1'b1;
        end else begin
            if (c == "v") c = "b";
            else if (c == "w") c = "j";
            else if (c == "y") c = "o";
            else if (c == "x") c = "u";
        end
        if (c < "a" || c > "u") begin
            c   = "x";
            bad = 1'b1;
        end
        code = c - "a";
    endfunction

    // Advance the parse state by one byte and collect its results in step_results
    function automatic void predict_parse(input logic [7:0] b, input logic eoi);
        logic [7:0] code;
        logic       bad;
        step_results.delete();
        if (eoi) begin
            if (mdl_phase == PH_HEADER)
                step_results.push_back(mk_res(KIND_END, 8'd0, 20'd0, 1'b0, 1'b1, 1'b1));
            else if (mdl_phase == PH_SEQ)
                step_results.push_back(mk_res(KIND_END, 8'd0, mdl_seq_len, 1'b0, 1'b1, 1'b1));
            mdl_phase   = PH_SEEK;
            mdl_hdr_pos = 0;
            mdl_seq_len = '0;
        end else if (mdl_phase == PH_HEADER) begin
            if (b == CH_NL) begin
                mdl_phase   = PH_SEQ;
                mdl_seq_len = '0;
            end else if (mdl_hdr_pos < HEADER_LIMIT) begin
                mdl_hdr_pos++;
                step_results.push_back(mk_res(KIND_HEADER, b, 20'(mdl_hdr_pos),
                                              1'b0, 1'b0, 1'b1));
            end
        end else if (mdl_phase == PH_SEQ) begin
            if (b == CH_GT) begin
                step_results.push_back(mk_res(KIND_END, 8'd0, mdl_seq_len, 1'b0, 1'b0, 1'b0));
                step_results.push_back(mk_res(KIND_HEADER, b, 20'd0, 1'b0, 1'b0, 1'b1));
                mdl_phase   = PH_HEADER;
                mdl_hdr_pos = 0;
                mdl_seq_len = '0;
            end else if (b != CH_SP && b != CH_NL && b != CH_TAB) begin
                map_residue(b, mdl_dna, code, bad);
                step_results.push_back(mk_res(KIND_RESIDUE, code, mdl_seq_len, bad,
                                              1'b0, 1'b1));
                if (mdl_seq_len != '1) mdl_seq_len++;
            end
        end else if (b == CH_GT) begin
            mdl_phase   = PH_HEADER;
            mdl_hdr_pos = 0;
            mdl_seq_len = '0;
            step_results.push_back(mk_res(KIND_HEADER, b, 20'd0, 1'b0, 1'b0, 1'b1));
        end
    endfunction

    // Check results and apply transfers on every channel
    always @(posedge clk) begin : monitor
        t_result want;
        t_result got;
        if (rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got.kind     = t_kind'(out_if.result_kind);
                got.value    = out_if.value;
                got.position = out_if.position;
                got.invalid  = out_if.invalid_residue;
                got.done     = out_if.stream_done;
                got.last     = out_if.last_of_run;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d value=%0d position=%0d",
                             $time, got.kind, got.value, got.position);
                    failed = 1'b1;
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %p", $time, want);
                        $display("%0t:          actual   %p", $time, got);
                        failed = 1'b1;
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready)
                mdl_dna = cfg_if.alphabet_is_dna;
            if (in_if.valid && in_if.ready) begin
                predict_parse(in_if.text_byte, in_if.end_of_input);
                if (cur_typed) begin
                    for (int i = 0; i < cur_n; i++) pending_results.push_back(cur_res);
                end else begin
                    foreach (step_results[i]) pending_results.push_back(step_results[i]);
                end
            end
        end
    end

    // Result side: bursts of ready and stall, plus a long hold on request
    initial begin : rx_ready
        int span;
        out_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req > 0) begin
                span     = hold_req;
                hold_req = 0;
                out_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                span = $urandom_range(1, 16);
                out_if.ready <= 1'b0;
            end else begin
                span = $urandom_range(1, 24);
                out_if.ready <= 1'b1;
            end
            repeat (span - 1) @(negedge clk);
        end
    end

    // Offer one byte and hold it until its transfer
    task automatic send_item(input logic [7:0] b, input logic eoi, input bit typed,
                             input int n, input t_result res);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid        <= 1'b1;
        in_if.text_byte    <= b;
        in_if.end_of_input <= eoi;
        cur_typed = typed;
        cur_n     = n;
        cur_res   = res;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_plain(input logic [7:0] b, input logic eoi);
        send_item(b, eoi, 1'b0, 0, '0);
    endtask

    // Stop offering and wait until every expected result has come
    task automatic wait_drain();
        in_if.valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
    endtask

    task automatic write_alphabet(input logic dna);
        wait_drain();
        // let idle clocks clear the pipeline
        repeat (8) @(negedge clk);
        cfg_if.valid           <= 1'b1;
        cfg_if.alphabet_is_dna <= dna;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic void add_row(input t_row_op op, input logic [7:0] b, input bit typed,
                                    input int n, input t_result res);
        t_stim_row row;
        row.op    = op;
        row.b     = b;
        row.typed = typed;
        row.n     = n;
        row.res   = res;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [7:0] pick_seq_byte(input logic dna);
        string dna_set;
        int    r;
        logic [7:0] c;
        dna_set = "acgtnxACGTNXu";
        r = $urandom_range(0, 99);
        if (r < 65) begin
            if (dna) begin
                c = dna_set[$urandom_range(0, dna_set.len() - 1)];
            end else begin
                c = 8'("a" + $urandom_range(0, 25));
                if ($urandom_range(0, 1) == 1) c = c - 8'd32;
            end
        end else if (r < 78) begin
            case ($urandom_range(0, 2))
                0:       c = CH_SP;
                1:       c = CH_NL;
                default: c = CH_TAB;
            endcase
        end else if (r < 82) begin
            c = CH_CR;
        end else begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // One record: optional noise, header, newline, sequence, optional end of input
    task automatic send_record(input logic dna, inout int sent);
        int hlen;
        int slen;
        logic [7:0] b;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_GT) b = 8'h00;
                send_plain(b, 1'b0);
            end
        end
        if ($urandom_range(0, 15) == 0) send_plain(8'($urandom_range(0, 255)), 1'b1);
        send_plain(CH_GT, 1'b0);
        sent++;
        hlen = ($urandom_range(0, 7) == 0) ? $urandom_range(45, 60) : $urandom_range(0, 16);
        repeat (hlen) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_NL) b = "h";
            send_plain(b, 1'b0);
            sent++;
        end
        // end of input inside the header
        if ($urandom_range(0, 15) == 0) begin
            send_plain(8'($urandom_range(0, 255)), 1'b1);
            sent++;
            return;
        end
        send_plain(CH_NL, 1'b0);
        sent++;
        slen = $urandom_range(0, 40);
        repeat (slen) begin
            send_plain(pick_seq_byte(dna), 1'b0);
            sent++;
        end
        if ($urandom_range(0, 3) == 0) begin
            send_plain(8'($urandom_range(0, 255)), 1'b1);
            sent++;
        end
    endtask

    initial begin : stimulus
        int   sent;
        int   waited;
        logic dna;
        bit   paused;
        rst_n                  = 1'b0;
        in_if.valid            = 1'b0;
        in_if.text_byte        = 8'h00;
        in_if.end_of_input     = 1'b0;
        cfg_if.valid           = 1'b0;
        cfg_if.alphabet_is_dna = 1'b0;
        paused                 = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table, protein alphabet out of reset
        add_row(ROW_BYTE, "A",     1'b1, 0, '0);
        add_row(ROW_EOI,  8'h00,   1'b1, 0, '0);
        add_row(ROW_BYTE, CH_GT,   1'b1, 1,
                mk_res(KIND_HEADER, CH_GT, 20'd0, 1'b0, 1'b0, 1'b1));
        add_row(ROW_BYTE, 8'hFF,   1'b1, 1,
                mk_res(KIND_HEADER, 8'hFF, 20'd1, 1'b0, 1'b0, 1'b1));
        add_row(ROW_BYTE, 8'h00,   1'b1, 1,
                mk_res(KIND_HEADER, 8'h00, 20'd2, 1'b0, 1'b0, 1'b1));
        add_row(ROW_BYTE, CH_NL,   1'b1, 0, '0);
        add_row(ROW_BYTE, "A",     1'b1, 1,
                mk_res(KIND_RESIDUE, 8'd0, 20'd0, 1'b0, 1'b0, 1'b1));
        add_row(ROW_BYTE, "v",     1'b0, 0, '0);
        add_row(ROW_BYTE, "W",     1'b0, 0, '0);
        add_row(ROW_BYTE, "y",     1'b0, 0, '0);
        add_row(ROW_BYTE, "x",     1'b0, 0, '0);
        add_row(ROW_BYTE, 8'hFF,   1'b1, 1,
                mk_res(KIND_RESIDUE, CODE_INVALID, 20'd5, 1'b1, 1'b0, 1'b1));
        add_row(ROW_BYTE, CH_CR,   1'b1, 1,
                mk_res(KIND_RESIDUE, CODE_INVALID, 20'd6, 1'b1, 1'b0, 1'b1));
        add_row(ROW_BYTE, CH_SP,   1'b0, 0, '0);
        add_row(ROW_BYTE, CH_TAB,  1'b0, 0, '0);
        add_row(ROW_BYTE, CH_NL,   1'b0, 0, '0);
        add_row(ROW_BYTE, CH_GT,   1'b0, 0, '0);
        add_row(ROW_EOI,  8'hFF,   1'b1, 1,
                mk_res(KIND_END, 8'd0, 20'd0, 1'b0, 1'b1, 1'b1));
        // Nucleotide alphabet
        add_row(ROW_CFG,  8'h01,   1'b0, 0, '0);
        add_row(ROW_BYTE, CH_GT,   1'b0, 0, '0);
        add_row(ROW_BYTE, CH_NL,   1'b0, 0, '0);
        add_row(ROW_BYTE, "g",     1'b0, 0, '0);
        add_row(ROW_BYTE, "T",     1'b0, 0, '0);
        add_row(ROW_BYTE, "n",     1'b0, 0, '0);
        add_row(ROW_BYTE, "u",     1'b0, 0, '0);
        add_row(ROW_BYTE, 8'h00,   1'b0, 0, '0);
        add_row(ROW_EOI,  8'h00,   1'b0, 0, '0);

        foreach (dir_rows[i]) begin
            case (dir_rows[i].op)
                ROW_CFG: begin
                    write_alphabet(dir_rows[i].b[0]);
                end
                ROW_EOI: begin
                    send_item(dir_rows[i].b, 1'b1, dir_rows[i].typed, dir_rows[i].n,
                              dir_rows[i].res);
                end
                default: begin
                    send_item(dir_rows[i].b, 1'b0, dir_rows[i].typed, dir_rows[i].n,
                              dir_rows[i].res);
                end
            endcase
        end

        // Random records in four alphabet phases; the last one runs without idling
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       dna = 1'b0;
                1:       dna = 1'b1;
                2:       dna = 1'b0;
                default: dna = 1'($urandom_range(0, 1));
            endcase
            write_alphabet(dna);
            if (ph == 3) idle_on = 1'b0;
            sent = 0;
            if (ph == 2) hold_req = 300;
            while (sent < 400) begin
                if (ph == 1 && sent >= 200 && !paused) begin
                    wait_drain();
                    paused = 1'b1;
                end
                send_record(dna, sent);
            end
        end

        // Drain and let the pipeline settle
        in_if.valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 2000) begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
